@@ hw/rtl/sca_pkg.sv @@
`default_nettype none
package sca_pkg;

	typedef struct packed {
		logic [7:0] atr_byte;
		logic       first_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic       params_valid;
		logic [7:0] protocol_mask;
		logic [3:0] first_protocol;
		logic [7:0] fi_di_byte;
		logic [7:0] extra_guard;
		logic [7:0] wait_integer;
		logic [7:0] card_frame_size;
		logic [3:0] block_wait_index;
		logic [3:0] char_wait_index;
		logic       crc_check;
	} out_t;

	typedef enum logic [1:0] {
		PH_TS   = 2'd0,
		PH_T0   = 2'd1,
		PH_IF   = 2'd2,
		PH_TAIL = 2'd3
	} phase_t;

	typedef enum logic {
		OP_RESTART = 1'b0,
		OP_BYTE    = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       last;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} q_rd_t;

	localparam logic [7:0] TA1_DEFAULT  = 8'h11;
	localparam logic [7:0] WI_DEFAULT   = 8'd10;
	localparam logic [7:0] IFSC_DEFAULT = 8'd32;
	localparam logic [3:0] BWI_DEFAULT  = 4'd4;
	localparam logic [3:0] CWI_DEFAULT  = 4'd13;
	localparam logic [3:0] BWI_MAX      = 4'd9;
	localparam logic [7:0] PROTO_DEFAULT = 8'h01;
	localparam logic [1:0] GROUP_FIRST  = 2'd1;
	localparam logic [1:0] GROUP_SECOND = 2'd2;
	localparam logic [1:0] GROUP_LATE   = 2'd3;
	localparam logic [3:0] PROTO_T1     = 4'd1;
	localparam logic [3:0] MASK_TA      = 4'h1;
	localparam logic [3:0] MASK_TB      = 4'h2;
	localparam logic [3:0] MASK_TC      = 4'h4;
	localparam logic [3:0] MASK_TD      = 4'h8;

endpackage
`default_nettype wire

@@ hw/rtl/sca_queue.sv @@
`default_nettype none
module sca_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sca_pkg::entry_t wr_data,
	output logic                full,
	input  wire logic           pop,
	output sca_pkg::entry_t     rd_data,
	output logic                empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sca_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_IDX) ? '0 : rptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/sca_front.sv @@
`default_nettype none
module sca_front (
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire sca_pkg::in_t in_data,
	output sca_pkg::q_wr_t   q_wr_ctl,
	input  wire logic        q_full,
	output sca_pkg::entry_t  q_entry
);

	assign in_stall       = q_full;
	assign q_wr_ctl.push  = in_valid && !q_full;
	assign q_wr_ctl.full  = q_full;

	always_comb begin
		q_entry.op   = in_data.first_byte ? sca_pkg::OP_RESTART : sca_pkg::OP_BYTE;
		q_entry.last = in_data.last_byte;
		q_entry.data = in_data.atr_byte;
	end

endmodule
`default_nettype wire

@@ hw/rtl/sca_back.sv @@
`default_nettype none
module sca_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sca_pkg::q_rd_t q_rd_ctl,
	output logic             q_pop,
	input  wire sca_pkg::entry_t q_entry,
	output logic             out_valid,
	input  wire logic        out_stall,
	output sca_pkg::out_t    out_data
);

	sca_pkg::phase_t phase_q, n_phase;
	logic [3:0] pend_q, n_pend;
	logic [1:0] grp_q, n_grp;
	logic [3:0] cur_q, n_cur;
	logic       td_q, n_td;
	logic       saw_q, n_saw;
	logic [7:0] proto_q, n_proto;
	logic [3:0] fproto_q, n_fproto;
	logic [7:0] ta1_q, n_ta1;
	logic [7:0] guard_q, n_guard;
	logic [7:0] wi_q, n_wi;
	logic [7:0] ifsc_q, n_ifsc;
	logic [3:0] bwi_q, n_bwi;
	logic [3:0] cwi_q, n_cwi;
	logic       edc_q, n_edc;

	logic       out_valid_q;
	sca_pkg::out_t out_q;
	logic       emit, restart, t1_late;
	logic [7:0] v;
	logic [3:0] t;
	logic [7:0] t_bit;

	assign restart = (q_entry.op == sca_pkg::OP_RESTART);
	assign v       = q_entry.data;
	assign t       = v[3:0];
	assign t_bit   = t[3] ? 8'h00 : (8'h01 << t[2:0]);
	assign t1_late = (grp_q == sca_pkg::GROUP_LATE) && (cur_q == sca_pkg::PROTO_T1);

	// output decisions
	always_comb begin
		q_pop = !q_rd_ctl.empty && (!out_valid_q || !out_stall);
		emit  = q_entry.last && (restart || phase_q != sca_pkg::PH_TS);
	end

	// next parse state
	always_comb begin
		n_phase  = phase_q;
		n_pend   = pend_q;
		n_grp    = grp_q;
		n_cur    = cur_q;
		n_td     = td_q;
		n_saw    = saw_q;
		n_proto  = proto_q;
		n_fproto = fproto_q;
		n_ta1    = ta1_q;
		n_guard  = guard_q;
		n_wi     = wi_q;
		n_ifsc   = ifsc_q;
		n_bwi    = bwi_q;
		n_cwi    = cwi_q;
		n_edc    = edc_q;
		if (restart) begin
			n_phase  = sca_pkg::PH_T0;
			n_pend   = '0;
			n_grp    = sca_pkg::GROUP_FIRST;
			n_cur    = '0;
			n_td     = 1'b0;
			n_saw    = 1'b0;
			n_proto  = sca_pkg::PROTO_DEFAULT;
			n_fproto = '0;
			n_ta1    = sca_pkg::TA1_DEFAULT;
			n_guard  = '0;
			n_wi     = sca_pkg::WI_DEFAULT;
			n_ifsc   = sca_pkg::IFSC_DEFAULT;
			n_bwi    = sca_pkg::BWI_DEFAULT;
			n_cwi    = sca_pkg::CWI_DEFAULT;
			n_edc    = 1'b0;
		end else begin
			case (phase_q)
				sca_pkg::PH_T0: begin
					n_saw   = 1'b1;
					n_pend  = v[7:4];
					n_phase = (v[7:4] != 4'h0) ? sca_pkg::PH_IF : sca_pkg::PH_TAIL;
				end
				sca_pkg::PH_IF: begin
					if ((pend_q & sca_pkg::MASK_TA) != '0) begin
						n_pend = pend_q & ~sca_pkg::MASK_TA;
						if (grp_q == sca_pkg::GROUP_FIRST) begin
							n_ta1 = v;
						end else if (t1_late && v != 8'h00 && v != 8'hFF) begin
							n_ifsc = v;
						end
					end else if ((pend_q & sca_pkg::MASK_TB) != '0) begin
						n_pend = pend_q & (sca_pkg::MASK_TC | sca_pkg::MASK_TD);
						if (t1_late) begin
							n_bwi = (v[7:4] > sca_pkg::BWI_MAX) ? sca_pkg::BWI_MAX : v[7:4];
							n_cwi = v[3:0];
						end
					end else if ((pend_q & sca_pkg::MASK_TC) != '0) begin
						n_pend = pend_q & sca_pkg::MASK_TD;
						if (grp_q == sca_pkg::GROUP_FIRST) begin
							n_guard = v;
						end else if (grp_q == sca_pkg::GROUP_SECOND) begin
							n_wi = (v == 8'h00) ? sca_pkg::WI_DEFAULT : v;
						end else if (cur_q == sca_pkg::PROTO_T1) begin
							n_edc = v[0];
						end
					end else begin
						n_cur = t;
						if (!td_q) begin
							n_fproto = t;
							n_proto  = t_bit;
							n_td     = 1'b1;
						end else begin
							n_proto = proto_q | t_bit;
						end
						n_pend = v[7:4];
						if (grp_q != sca_pkg::GROUP_LATE) begin
							n_grp = grp_q + 2'd1;
						end
					end
					if (n_pend == 4'h0) begin
						n_phase = sca_pkg::PH_TAIL;
					end
				end
				default: begin
				end
			endcase
		end
		if (emit) begin
			n_phase = sca_pkg::PH_TS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sca_pkg::PH_TS;
			pend_q      <= '0;
			grp_q       <= sca_pkg::GROUP_FIRST;
			cur_q       <= '0;
			td_q        <= 1'b0;
			saw_q       <= 1'b0;
			proto_q     <= sca_pkg::PROTO_DEFAULT;
			fproto_q    <= '0;
			ta1_q       <= sca_pkg::TA1_DEFAULT;
			guard_q     <= '0;
			wi_q        <= sca_pkg::WI_DEFAULT;
			ifsc_q      <= sca_pkg::IFSC_DEFAULT;
			bwi_q       <= sca_pkg::BWI_DEFAULT;
			cwi_q       <= sca_pkg::CWI_DEFAULT;
			edc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q  <= n_phase;
				pend_q   <= n_pend;
				grp_q    <= n_grp;
				cur_q    <= n_cur;
				td_q     <= n_td;
				saw_q    <= n_saw;
				proto_q  <= n_proto;
				fproto_q <= n_fproto;
				ta1_q    <= n_ta1;
				guard_q  <= n_guard;
				wi_q     <= n_wi;
				ifsc_q   <= n_ifsc;
				bwi_q    <= n_bwi;
				cwi_q    <= n_cwi;
				edc_q    <= n_edc;
				out_valid_q <= emit;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_q.params_valid     <= n_saw;
			out_q.protocol_mask    <= n_proto;
			out_q.first_protocol   <= n_fproto;
			out_q.fi_di_byte       <= n_ta1;
			out_q.extra_guard      <= n_guard;
			out_q.wait_integer     <= n_wi;
			out_q.card_frame_size  <= n_ifsc;
			out_q.block_wait_index <= n_bwi;
			out_q.char_wait_index  <= n_cwi;
			out_q.crc_check        <= n_edc;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ hw/rtl/smart_card_atr_parser.sv @@
`default_nettype none
// ATR parser: takes one answer-to-reset byte per request with first/last
// marks and returns one parameter set per last byte of an ATR opened by a
// first byte. Accepts one byte every cycle unless the queue is full; the
// back end updates its state in one registered step per byte, so throughput
// is one byte per clock unless the output stalls. A byte waits in the queue,
// then its result is registered at the output. The input stalls only when
// the queue is full, the output register holds a result under stall.
module smart_card_atr_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire sca_pkg::in_t in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output sca_pkg::out_t  out_data
);

	sca_pkg::q_wr_t  q_wr_ctl;
	sca_pkg::q_rd_t  q_rd_ctl;
	sca_pkg::entry_t q_wr_entry, q_rd_entry;
	logic q_full, q_empty, q_pop;

	assign q_rd_ctl.pop   = q_pop;
	assign q_rd_ctl.empty = q_empty;

	sca_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_wr_ctl (q_wr_ctl),
		.q_full   (q_full),
		.q_entry  (q_wr_entry)
	);

	sca_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_wr_ctl.push),
		.wr_data (q_wr_entry),
		.full    (q_full),
		.pop     (q_rd_ctl.pop),
		.rd_data (q_rd_entry),
		.empty   (q_empty)
	);

	sca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_rd_ctl  (q_rd_ctl),
		.q_pop     (q_pop),
		.q_entry   (q_rd_entry),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sca_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_BYTES   = 830;

	class atr_param_board;
		out_t     expected_params[$];
		phase_t   phase;
		logic [3:0] pend;
		logic [1:0] grp;
		logic [3:0] cur_proto;
		bit       td_seen;
		out_t     params;
		int       mismatches;
		int       sets_checked;

		function new();
			phase = PH_TS;
			load_defaults();
			mismatches = 0;
			sets_checked = 0;
		endfunction

		function void load_defaults();
			pend = '0;
			grp = GROUP_FIRST;
			cur_proto = '0;
			td_seen = 1'b0;
			params = '{params_valid: 1'b0, protocol_mask: PROTO_DEFAULT,
				first_protocol: 4'd0, fi_di_byte: TA1_DEFAULT, extra_guard: 8'd0,
				wait_integer: WI_DEFAULT, card_frame_size: IFSC_DEFAULT,
				block_wait_index: BWI_DEFAULT, char_wait_index: CWI_DEFAULT,
				crc_check: 1'b0};
		endfunction

		function void take_interface_byte(logic [7:0] v);
			bit late_t1;
			logic [3:0] t;
			late_t1 = (grp == GROUP_LATE) && (cur_proto == PROTO_T1);
			if ((pend & MASK_TA) != 0) begin
				pend = pend & ~MASK_TA;
				if (grp == GROUP_FIRST)
					params.fi_di_byte = v;
				else if (late_t1 && v != 8'h00 && v != 8'hFF)
					params.card_frame_size = v;
			end else if ((pend & MASK_TB) != 0) begin
				pend = pend & ~MASK_TB;
				if (late_t1) begin
					params.block_wait_index = (v[7:4] > BWI_MAX) ? BWI_MAX : v[7:4];
					params.char_wait_index = v[3:0];
				end
			end else if ((pend & MASK_TC) != 0) begin
				pend = pend & ~MASK_TC;
				if (grp == GROUP_FIRST)
					params.extra_guard = v;
				else if (grp == GROUP_SECOND)
					params.wait_integer = (v == 8'd0) ? WI_DEFAULT : v;
				else if (cur_proto == PROTO_T1)
					params.crc_check = v[0];
			end else begin
				// TDi: next group's mask and protocol
				t = v[3:0];
				cur_proto = t;
				if (t < 8)
					params.protocol_mask[t[2:0]] = 1'b1;
				if (!td_seen) begin
					params.first_protocol = t;
					params.protocol_mask = (t < 8) ? (8'h01 << t) : 8'h00;
					td_seen = 1'b1;
				end
				pend = v[7:4];
				if (grp != GROUP_LATE)
					grp = grp + 2'd1;
				if (pend == 0)
					phase = PH_TAIL;
				return;
			end
			if (pend == 0)
				phase = PH_TAIL;
		endfunction

		function void note_request(in_t req);
			if (req.first_byte) begin
				load_defaults();
				phase = PH_T0;
			end else if (phase == PH_TS) begin
				return;
			end else if (phase == PH_T0) begin
				params.params_valid = 1'b1;
				pend = req.atr_byte[7:4];
				phase = (pend != 0) ? PH_IF : PH_TAIL;
			end else if (phase == PH_IF) begin
				take_interface_byte(req.atr_byte);
			end
			if (req.last_byte) begin
				expected_params.push_back(params);
				phase = PH_TS;
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch: %s", $time, msg);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want)
				report($sformatf("%s expected %0h got %0h", name, want, got));
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_params.size() == 0) begin
				report($sformatf("parameter set %0h with none outstanding", got));
				return;
			end
			want = expected_params.pop_front();
			sets_checked++;
			check_field("params_valid", 8'(want.params_valid), 8'(got.params_valid));
			check_field("protocol_mask", want.protocol_mask, got.protocol_mask);
			check_field("first_protocol", 8'(want.first_protocol),
				8'(got.first_protocol));
			check_field("fi_di_byte", want.fi_di_byte, got.fi_di_byte);
			check_field("extra_guard", want.extra_guard, got.extra_guard);
			check_field("wait_integer", want.wait_integer, got.wait_integer);
			check_field("card_frame_size", want.card_frame_size, got.card_frame_size);
			check_field("block_wait_index", 8'(want.block_wait_index),
				8'(got.block_wait_index));
			check_field("char_wait_index", 8'(want.char_wait_index),
				8'(got.char_wait_index));
			check_field("crc_check", 8'(want.crc_check), 8'(got.crc_check));
		endfunction

		function int outstanding();
			return expected_params.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	atr_param_board board = new();
	bit idle_on;
	int atr_bytes_sent;
	int stray_bytes_sent;
	int quiet_cycles;

	smart_card_atr_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_request(in_data);
			if (out_valid && !out_stall)
				board.check_result(out_data);
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_data <= '{atr_byte: b, first_byte: first, last_byte: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random_atr();
		logic [7:0] atr[$];
		logic [7:0] t0;
		logic [3:0] flags;
		logic [3:0] next_flags;
		logic [3:0] proto;
		int groups;
		int last_at;
		int restart_at;
		atr.push_back(pick_byte());
		t0[7:4] = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 3) != 0)
			t0[7] = 1'b1;
		t0[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
			: 4'($urandom_range(0, 3));
		atr.push_back(t0);
		flags = t0[7:4];
		groups = 1;
		while (flags != 0) begin
			if (flags[0])
				atr.push_back(pick_byte());
			if (flags[1])
				atr.push_back(pick_byte());
			if (flags[2])
				atr.push_back(pick_byte());
			if (flags[3]) begin
				next_flags = 4'($urandom_range(0, 15));
				if (groups < 3 && $urandom_range(0, 1) == 0)
					next_flags[3] = 1'b1;
				if (groups >= 5)
					next_flags[3] = 1'b0;
				proto = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 1));
				atr.push_back({next_flags, proto});
				groups++;
				flags = next_flags;
			end else begin
				flags = 4'd0;
			end
		end
		repeat (t0[3:0]) atr.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 1) == 0)
			atr.push_back(8'($urandom_range(0, 255)));
		last_at = atr.size() - 1;
		restart_at = -1;
		case ($urandom_range(0, 9))
			0: last_at = $urandom_range(0, last_at);
			1: restart_at = $urandom_range(1, last_at);
			2: last_at = -1;
			default: ;
		endcase
		for (int i = 0; i < atr.size(); i++)
			send_byte(atr[i], i == 0 || i == restart_at, i == last_at);
		atr_bytes_sent += atr.size();
	endtask

	initial begin
		bit drained;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		idle_on = 1'b1;
		atr_bytes_sent = 0;
		stray_bytes_sent = 0;
		drained = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray byte before any TS, lone TS, TS with bare T0
		send_byte(8'hA5, 1'b0, 1'b1);
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h3B, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		// every interface byte through group 3 and TA4, field extremes
		send_byte(8'h3B, 1'b1, 1'b0);
		send_byte(8'hF2, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hF1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hF1, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hFA, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h1F, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
		// restart in the middle of an ATR
		send_byte(8'h3B, 1'b1, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'h3F, 1'b1, 1'b0);
		send_byte(8'h10, 1'b0, 1'b0);
		send_byte(8'h97, 1'b0, 1'b1);

		while (atr_bytes_sent < RANDOM_BYTES) begin
			idle_on = (atr_bytes_sent < 300)
				|| (atr_bytes_sent >= 420 && atr_bytes_sent < 680);
			if (!drained && atr_bytes_sent >= 300) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				do @(negedge clk); while (board.outstanding() != 0);
			end
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
						$urandom_range(0, 1) == 1);
					stray_bytes_sent++;
				end
			end else begin
				send_random_atr();
			end
		end
		in_valid <= 1'b0;

		while (board.outstanding() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("Sent %0d ATR bytes and %0d stray bytes; %0d parameter sets checked.",
			atr_bytes_sent, stray_bytes_sent, board.sets_checked);
		$display("Field mismatches and unexpected sets: %0d", board.mismatches);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
